[rtl/core/itoa_fmt_pkg.sv]
// Package for the integer-to-ASCII field formatter: codes, character constants,
// the microcode word layout and the microcode program ROM.
// No dependencies; imported by the formatter top level.
package itoa_fmt_pkg;

    localparam int MAX_WIDTH_DEF  = 48;
    localparam int VALUE_BITS_DEF = 32;

    // Conversion codes.
    localparam logic [1:0] OP_DEC = 2'd0;
    localparam logic [1:0] OP_HEX = 2'd1;
    localparam logic [1:0] OP_PTR = 2'd2;
    localparam logic [1:0] OP_OCT = 2'd3;

    // Pad modes; the unused code behaves as left spaces.
    localparam logic [1:0] PAD_LEFT_SPACE  = 2'd0;
    localparam logic [1:0] PAD_LEFT_ZERO   = 2'd1;
    localparam logic [1:0] PAD_RIGHT_SPACE = 2'd2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_A_BASE = 8'h57;  // 'a' minus ten

    // Digit buffer: never more than sixteen digits per item.
    localparam int DIG_DEPTH    = 16;
    localparam int DIG_IDX_BITS = $clog2(DIG_DEPTH);

    // Reciprocal of ten: floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for 32-bit x.
    localparam logic [32:0] RECIP10       = 33'h0CCCCCCCD;
    localparam int          RECIP10_SHIFT = 35;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_MINUS,
        EM_ZERO,
        EM_X,
        EM_PAD,
        EM_DIGIT
    } t_emit;

    typedef enum logic [2:0] {
        CD_ALWAYS,
        CD_INPUT,
        CD_NEG,
        CD_PTR,
        CD_PADL,
        CD_PADR
    } t_cond;

    typedef logic [2:0] t_step;

    localparam t_step ST_IDLE  = 3'd0;
    localparam t_step ST_CONV  = 3'd1;
    localparam t_step ST_MINUS = 3'd2;
    localparam t_step ST_ZERO  = 3'd3;
    localparam t_step ST_X     = 3'd4;
    localparam t_step ST_PADL  = 3'd5;
    localparam t_step ST_DIGIT = 3'd6;
    localparam t_step ST_PADR  = 3'd7;

    // One control word. A step whose condition is false either holds (hold set)
    // or jumps to nxt. A step whose condition is true repeats until its work is
    // done and then jumps to nxt.
    typedef struct packed {
        t_emit emit;
        t_cond cond;
        logic  hold;
        logic  load;
        logic  conv;
        t_step nxt;
    } t_uword;

    function automatic t_uword uc_word(input t_emit emit, input t_cond cond,
                                       input logic hold, input logic load,
                                       input logic conv, input t_step nxt);
        t_uword w;
        w.emit = emit;
        w.cond = cond;
        w.hold = hold;
        w.load = load;
        w.conv = conv;
        w.nxt  = nxt;
        return w;
    endfunction

    function automatic t_uword uc_rom(input t_step pc);
        t_uword w;
        case (pc)
            ST_IDLE:  w = uc_word(EM_NONE,  CD_INPUT,  1'b1, 1'b1, 1'b0, ST_CONV);
            ST_CONV:  w = uc_word(EM_NONE,  CD_ALWAYS, 1'b0, 1'b0, 1'b1, ST_MINUS);
            ST_MINUS: w = uc_word(EM_MINUS, CD_NEG,    1'b0, 1'b0, 1'b0, ST_ZERO);
            ST_ZERO:  w = uc_word(EM_ZERO,  CD_PTR,    1'b0, 1'b0, 1'b0, ST_X);
            ST_X:     w = uc_word(EM_X,     CD_PTR,    1'b0, 1'b0, 1'b0, ST_PADL);
            ST_PADL:  w = uc_word(EM_PAD,   CD_PADL,   1'b0, 1'b0, 1'b0, ST_DIGIT);
            ST_DIGIT: w = uc_word(EM_DIGIT, CD_ALWAYS, 1'b0, 1'b0, 1'b0, ST_PADR);
            ST_PADR:  w = uc_word(EM_PAD,   CD_PADR,   1'b0, 1'b0, 1'b0, ST_IDLE);
            default:  w = uc_word(EM_NONE,  CD_INPUT,  1'b1, 1'b1, 1'b0, ST_CONV);
        endcase
        return w;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + 8'(d);
        end else begin
            c = CH_A_BASE + 8'(d);
        end
        return c;
    endfunction

endpackage

[rtl/core/integer_to_ascii_field_formatter.sv]
// Integer-to-ASCII field formatter: microcoded sequencer and its datapath.
// Depends on itoa_fmt_pkg for codes, constants and the microcode ROM.
//
// Each input transaction carries a number, a conversion code (signed decimal,
// lower-case hex, pointer hex with a 0x prefix, octal), a minimum field width and a
// pad mode; the block answers with one output transaction per ASCII character,
// most significant digit first, with o_last high on the final character. A minus
// sign or the 0x prefix comes first and does not count toward the width; widths
// above MAX_WIDTH saturate. One item is processed at a time: o_ready is high only
// while the sequencer sits in its idle step. An item is loaded in the idle step,
// then converted one digit per cycle (one divide-by-ten, or a shift, per cycle),
// then passes the sign, prefix, left pad, digit and right pad steps, emitting one
// character per cycle while i_ready stays high; a sign, prefix or pad step that
// the item skips is still passed through. The digit conversion loop and the
// single-character output register set the pace of the block.
module integer_to_ascii_field_formatter
    import itoa_fmt_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    input  logic [1:0]  i_op,
    input  logic [5:0]  i_field_width,
    input  logic [1:0]  i_pad_mode,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_char,
    output logic        o_last
);

    // Sequencer and item registers.
    t_step                   r_pc, n_pc;
    logic [VALUE_BITS-1:0]   r_mag, n_mag;
    logic [1:0]              r_op, n_op;
    logic [5:0]              r_width, n_width;
    logic                    r_neg, n_neg;
    logic                    r_pad_zero, n_pad_zero;
    logic                    r_pad_right, n_pad_right;
    logic [DIG_IDX_BITS-1:0] r_nd, n_nd;
    logic [DIG_IDX_BITS-1:0] r_dig_idx, n_dig_idx;
    logic [5:0]              r_pad_cnt, n_pad_cnt;
    logic [3:0]              r_digs [DIG_DEPTH];

    // Output register.
    logic                    r_o_valid, n_o_valid;
    logic [7:0]              r_o_char, n_o_char;
    logic                    r_o_last, n_o_last;

    t_uword                  uw;
    logic                    cond_ok;
    logic                    out_free;
    logic                    dig_we;

    // Input decode.
    logic [VALUE_BITS-1:0]   v_in;
    logic                    in_neg;
    logic [5:0]              w_sat;

    // Digit extraction.
    logic [31:0]             mag32;
    logic [64:0]             prod;
    logic [31:0]             q32;
    logic [31:0]             rem32;
    logic [3:0]              digit_next;
    logic [VALUE_BITS-1:0]   mag_next;
    logic                    conv_done;
    logic [4:0]              nd_total;
    logic [5:0]              nd6;
    logic [5:0]              pad_calc;

    assign uw       = uc_rom(r_pc);
    assign out_free = !r_o_valid || i_ready;

    assign v_in   = i_value[VALUE_BITS-1:0];
    assign in_neg = (i_op == OP_DEC) && v_in[VALUE_BITS-1];
    assign w_sat  = (i_field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : i_field_width;

    // Decimal digit by reciprocal multiplication; the remainder uses shift-adds.
    assign mag32 = 32'(r_mag);
    assign prod  = 65'(mag32) * 65'(RECIP10);
    assign q32   = 32'(prod >> RECIP10_SHIFT);
    assign rem32 = mag32 - ((q32 << 3) + (q32 << 1));

    always_comb begin
        case (r_op)
            OP_DEC: begin
                digit_next = rem32[3:0];
                mag_next   = q32[VALUE_BITS-1:0];
            end
            OP_OCT: begin
                digit_next = {1'b0, r_mag[2:0]};
                mag_next   = r_mag >> 3;
            end
            default: begin
                digit_next = r_mag[3:0];
                mag_next   = r_mag >> 4;
            end
        endcase
    end

    assign conv_done = (mag_next == '0) || (r_nd == {DIG_IDX_BITS{1'b1}});
    assign nd_total  = 5'(r_nd) + 5'd1;
    assign nd6       = 6'(nd_total);
    assign pad_calc  = (r_width > nd6) ? (r_width - nd6) : 6'd0;

    always_comb begin
        case (uw.cond)
            CD_ALWAYS: cond_ok = 1'b1;
            CD_INPUT:  cond_ok = i_valid;
            CD_NEG:    cond_ok = r_neg;
            CD_PTR:    cond_ok = (r_op == OP_PTR);
            CD_PADL:   cond_ok = !r_pad_right && (r_pad_cnt != 6'd0);
            CD_PADR:   cond_ok = r_pad_right && (r_pad_cnt != 6'd0);
            default:   cond_ok = 1'b0;
        endcase
    end

    // Step execution: the control word chooses what the datapath does this cycle.
    always_comb begin
        n_pc        = r_pc;
        n_mag       = r_mag;
        n_op        = r_op;
        n_width     = r_width;
        n_neg       = r_neg;
        n_pad_zero  = r_pad_zero;
        n_pad_right = r_pad_right;
        n_nd        = r_nd;
        n_dig_idx   = r_dig_idx;
        n_pad_cnt   = r_pad_cnt;
        n_o_valid   = r_o_valid && !i_ready;
        n_o_char    = r_o_char;
        n_o_last    = r_o_last;
        dig_we      = 1'b0;

        if (!cond_ok) begin
            if (!uw.hold) begin
                n_pc = uw.nxt;
            end
        end else if (uw.load) begin
            n_mag       = in_neg ? (~v_in + 1'b1) : v_in;
            n_op        = i_op;
            n_width     = w_sat;
            n_neg       = in_neg;
            n_pad_zero  = (i_pad_mode == PAD_LEFT_ZERO);
            n_pad_right = (i_pad_mode == PAD_RIGHT_SPACE);
            n_nd        = '0;
            n_pc        = uw.nxt;
        end else if (uw.conv) begin
            dig_we = 1'b1;
            n_mag  = mag_next;
            if (conv_done) begin
                n_dig_idx = r_nd;
                n_pad_cnt = pad_calc;
                n_pc      = uw.nxt;
            end else begin
                n_nd = r_nd + 1'b1;
            end
        end else if (uw.emit == EM_NONE) begin
            n_pc = uw.nxt;
        end else if (out_free) begin
            n_o_valid = 1'b1;
            n_o_last  = 1'b0;
            case (uw.emit)
                EM_MINUS: begin
                    n_o_char = CH_MINUS;
                    n_pc     = uw.nxt;
                end
                EM_ZERO: begin
                    n_o_char = CH_ZERO;
                    n_pc     = uw.nxt;
                end
                EM_X: begin
                    n_o_char = CH_X;
                    n_pc     = uw.nxt;
                end
                EM_PAD: begin
                    n_o_char  = r_pad_zero ? CH_ZERO : CH_SPACE;
                    n_o_last  = r_pad_right && (r_pad_cnt == 6'd1);
                    n_pad_cnt = r_pad_cnt - 6'd1;
                    if (r_pad_cnt == 6'd1) begin
                        n_pc = uw.nxt;
                    end
                end
                EM_DIGIT: begin
                    n_o_char = digit_char(r_digs[r_dig_idx]);
                    n_o_last = (r_dig_idx == '0) && !(r_pad_right && (r_pad_cnt != 6'd0));
                    if (r_dig_idx == '0) begin
                        n_pc = uw.nxt;
                    end else begin
                        n_dig_idx = r_dig_idx - 1'b1;
                    end
                end
                default: begin
                    n_o_valid = r_o_valid && !i_ready;
                    n_pc      = uw.nxt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_pc      <= n_pc;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag       <= n_mag;
        r_op        <= n_op;
        r_width     <= n_width;
        r_neg       <= n_neg;
        r_pad_zero  <= n_pad_zero;
        r_pad_right <= n_pad_right;
        r_nd        <= n_nd;
        r_dig_idx   <= n_dig_idx;
        r_pad_cnt   <= n_pad_cnt;
        r_o_char    <= n_o_char;
        r_o_last    <= n_o_last;
    end

    // Digits are stored least significant first and read back in reverse.
    always_ff @(posedge i_clk) begin
        if (dig_we) begin
            r_digs[r_nd] <= digit_next;
        end
    end

    assign o_ready    = (r_pc == ST_IDLE);
    assign o_valid    = r_o_valid;
    assign o_out_char = r_o_char;
    assign o_last     = r_o_last;

endmodule

[rtl/core/itoa_fmt_checker.sv]
// Port-level checker for the integer-to-ASCII field formatter, with its bind.
// No package dependency; it watches only the top level's ports.
module itoa_fmt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_char,
    input logic       o_last
);

    // A stalled output transaction keeps its character and flag.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_char) && $stable(o_last))
        else $error("output transaction changed while stalled");

    // Once an item is taken, no new one is taken on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while the previous item is still in work");

    // While a character that is not the last one is shown, the item is unfinished.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("ready for a new item before the last character");

    // Only digits, lower-case hex letters, space, minus and x appear.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_out_char >= 8'h30) && (o_out_char <= 8'h39))
                 || ((o_out_char >= 8'h61) && (o_out_char <= 8'h66))
                 || (o_out_char == 8'h20) || (o_out_char == 8'h2D)
                 || (o_out_char == 8'h78))
        else $error("unexpected output character");

endmodule

bind integer_to_ascii_field_formatter itoa_fmt_checker u_itoa_fmt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_char (o_out_char),
    .o_last     (o_last)
);

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench for integer_to_ascii_field_formatter: random and directed numbers go in
// and every output character is checked against a behavioral predictor.
// Depends on itoa_fmt_pkg for conversion codes, pad modes and character constants.
module tb;
    import itoa_fmt_pkg::*;

    // The package names three pad modes; the fourth code must act as left spaces.
    localparam logic [1:0] PAD_UNUSED = 2'd3;

    // Lower-case digit set, leftmost character in the top byte.
    localparam logic [127:0] HEX_CHARS = "0123456789abcdef";

    // Cycles without any accepted transaction on either channel before giving up.
    // The slowest legal stretch is the deliberate receiver hold, so this leaves
    // a wide margin.
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;

    // Keeps the characters that accepted numbers still owe and compares every
    // output transaction with the oldest one.
    class fmt_scoreboard;
        typedef struct packed {
            logic [7:0] ch;
            logic       last;
        } char_t;

        char_t pending_chars[$];
        int    mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void push_char(logic [7:0] ch);
            char_t c;
            c.ch   = ch;
            c.last = 1'b0;
            pending_chars.push_back(c);
        endfunction

        // Formats one number exactly as the block should and queues the result.
        function void note_item(logic [31:0] value, logic [1:0] op,
                                logic [5:0] fw, logic [1:0] pad);
            logic [31:0] vmask;
            logic [31:0] mag;
            logic [3:0]  d;
            logic [7:0]  digs[16];
            logic [1:0]  pmode;
            int unsigned nd;
            int unsigned width;
            int unsigned padn;
            char_t       tail;
            vmask = (VALUE_BITS_DEF >= 32) ? 32'hFFFF_FFFF
                                           : (32'd1 << VALUE_BITS_DEF) - 32'd1;
            mag   = value & vmask;
            width = (fw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : fw;
            pmode = (pad == PAD_UNUSED) ? PAD_LEFT_SPACE : pad;
            nd    = 0;

            // The sign and the pointer prefix sit outside the field width.
            if (op == OP_DEC) begin
                if (mag[VALUE_BITS_DEF-1]) begin
                    push_char(CH_MINUS);
                    mag = (32'd0 - mag) & vmask;
                end
            end else if (op == OP_PTR) begin
                push_char(CH_ZERO);
                push_char(CH_X);
            end

            // Collect digits least significant first; zero still yields one digit.
            do begin
                if (op == OP_DEC) begin
                    d   = 4'(mag % 32'd10);
                    mag = mag / 32'd10;
                end else if (op == OP_OCT) begin
                    d   = 4'(mag[2:0]);
                    mag = mag >> 3;
                end else begin
                    d   = mag[3:0];
                    mag = mag >> 4;
                end
                digs[nd] = HEX_CHARS[8*(15-d) +: 8];
                nd++;
            end while (mag != 0 && nd < 16);

            padn = (width > nd) ? width - nd : 0;
            if (pmode != PAD_RIGHT_SPACE) begin
                for (int i = 0; i < padn; i++) begin
                    push_char((pmode == PAD_LEFT_ZERO) ? CH_ZERO : CH_SPACE);
                end
            end
            for (int i = nd; i > 0; i--) begin
                push_char(digs[i-1]);
            end
            if (pmode == PAD_RIGHT_SPACE) begin
                for (int i = 0; i < padn; i++) begin
                    push_char(CH_SPACE);
                end
            end

            tail = pending_chars.pop_back();
            tail.last = 1'b1;
            pending_chars.push_back(tail);
        endfunction

        function void check_char(logic [7:0] ch, logic last);
            char_t want;
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected character %h last %b at %0t", ch, last, $time);
                end
            end else begin
                want = pending_chars.pop_front();
                if (want.ch !== ch || want.last !== last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("char mismatch at %0t: expected %h last %b, got %h last %b",
                                 $time, want.ch, want.last, ch, last);
                    end
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_value = '0;
    logic [1:0]  i_op = OP_DEC;
    logic [5:0]  i_field_width = '0;
    logic [1:0]  i_pad_mode = PAD_LEFT_SPACE;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_char;
    logic        o_last;

    fmt_scoreboard sb;

    // Idle odds in percent for each side, changed between test phases.
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    // A nonzero value asks the receiver process to hold i_ready low that long.
    int rcv_hold_req = 0;

    integer_to_ascii_field_formatter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .i_op          (i_op),
        .i_field_width (i_field_width),
        .i_pad_mode    (i_pad_mode),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_char    (o_out_char),
        .o_last        (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Output side. Signals are read right at the rising edge, so they hold their
    // pre-edge values and a transaction is exactly valid and ready seen here.
    // A requested hold keeps i_ready low for a long stretch while the sender
    // keeps offering, so the block backs up and drops o_ready.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                sb.check_char(o_out_char, o_last);
            end
            if (rcv_hold_req > 0) begin
                hold_left    = rcv_hold_req;
                rcv_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Watchdog: any transaction on either channel restarts the count.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb NOT OK");
        $finish;
    end

    // Offers one number and returns at the edge where it is accepted. Valid is
    // only lowered when a gap is inserted, so back-to-back items never see a
    // low and a high assignment in the same time step.
    task automatic send_item(logic [31:0] value, logic [1:0] op,
                             logic [5:0] fw, logic [1:0] pad);
        if ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        i_valid       <= 1'b1;
        i_value       <= value;
        i_op          <= op;
        i_field_width <= fw;
        i_pad_mode    <= pad;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(value, op, fw, pad);
    endtask

    // Random numbers: mostly short fields so the run stays quick, with some
    // wide and some saturating widths, and values aimed at small magnitudes,
    // small negatives, powers of two and full 32-bit patterns.
    task automatic send_random(int count);
        logic [31:0] value;
        logic [5:0]  fw;
        int          pick;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0: value = $urandom_range(20);
                1: value = $urandom;
                2: value = 32'd0 - 32'($urandom_range(1, 1000));
                default: value = (32'd1 << $urandom_range(31)) - 32'($urandom_range(1));
            endcase
            pick = $urandom_range(99);
            if (pick < 65) begin
                fw = 6'($urandom_range(15));
            end else if (pick < 90) begin
                fw = 6'($urandom_range(16, MAX_WIDTH_DEF));
            end else begin
                fw = 6'($urandom_range(MAX_WIDTH_DEF + 1, 63));
            end
            send_item(value, 2'($urandom_range(3)), fw, 2'($urandom_range(3)));
        end
    endtask

    // Stops offering and waits until every owed character has come out.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_chars.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase one: sender rarely idles, receiver often stalls.
        snd_idle_pct = 9;
        rcv_idle_pct = 53;

        // Zero in every conversion prints a single digit.
        send_item(32'd0, OP_DEC, 6'd0, PAD_LEFT_SPACE);
        send_item(32'd0, OP_HEX, 6'd0, PAD_LEFT_SPACE);
        send_item(32'd0, OP_PTR, 6'd0, PAD_LEFT_SPACE);
        send_item(32'd0, OP_OCT, 6'd0, PAD_LEFT_SPACE);
        // Most negative decimal, bare and zero padded after the sign.
        send_item(32'h8000_0000, OP_DEC, 6'd0, PAD_LEFT_SPACE);
        send_item(32'h8000_0000, OP_DEC, 6'd20, PAD_LEFT_ZERO);
        // All ones in every conversion.
        send_item(32'hFFFF_FFFF, OP_DEC, 6'd5, PAD_RIGHT_SPACE);
        send_item(32'hFFFF_FFFF, OP_HEX, 6'd0, PAD_LEFT_SPACE);
        send_item(32'hFFFF_FFFF, OP_PTR, 6'd12, PAD_LEFT_ZERO);
        send_item(32'hFFFF_FFFF, OP_OCT, 6'd0, PAD_LEFT_SPACE);
        // Width equal to and below the digit count: no padding.
        send_item(32'h7FFF_FFFF, OP_DEC, 6'd10, PAD_LEFT_ZERO);
        send_item(32'd255, OP_PTR, 6'd1, PAD_RIGHT_SPACE);
        send_item(32'd9, OP_DEC, 6'd1, PAD_LEFT_ZERO);
        // The largest legal width and widths that saturate.
        send_item(32'd12345, OP_DEC, 6'd48, PAD_LEFT_SPACE);
        send_item(32'd12345, OP_DEC, 6'd63, PAD_RIGHT_SPACE);
        send_item(32'd12345, OP_DEC, 6'd49, PAD_LEFT_ZERO);
        send_item(32'd8, OP_OCT, 6'd63, PAD_LEFT_ZERO);
        send_item(32'hDEAD_BEEF, OP_HEX, 6'd48, PAD_RIGHT_SPACE);
        // The spare pad code must pad on the left with spaces.
        send_item(32'd255, OP_HEX, 6'd8, PAD_UNUSED);
        send_item(32'hDEAD_BEEF, OP_DEC, 6'd30, PAD_UNUSED);

        send_random(75);
        wait_drained();

        // Phase two: the roles swap.
        snd_idle_pct = 53;
        rcv_idle_pct = 9;
        send_random(75);
        wait_drained();

        // Phase three: no idling, opened by a long receiver hold so the block
        // fills and refuses input while the sender keeps trying.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        rcv_hold_req = 300;
        send_random(50);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

[integer_to_ascii_field_formatter.f]
rtl/core/itoa_fmt_pkg.sv
rtl/core/integer_to_ascii_field_formatter.sv
rtl/core/itoa_fmt_checker.sv
verif/tb.sv
